// File: rtl/core/sslk_pkg.sv
// ============================================================================
// sslk_pkg
// Shared types and constants for the sorted set membership lookup core.
// ============================================================================
`default_nettype none

package sslk_pkg;

  // Table depth and derived widths.
  localparam int DEPTH      = 256;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int VAL_W      = 16;
  localparam int CMD_W      = 2;
  localparam int COUNT_W    = 9;

  // Hit flags are OR-reduced in groups of this size, one register level per stage.
  localparam int GROUP      = 16;
  localparam int NUM_GROUPS = (DEPTH + GROUP - 1) / GROUP;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  // Strobes broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic clear;
    logic insert;
    logic sample;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/sslk_req_if.sv
// ============================================================================
// sslk_req_if
// Request channel: command and value with a valid/ready handshake.
// ============================================================================
`default_nettype none

interface sslk_req_if import sslk_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [VAL_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sslk_rsp_if.sv
// ============================================================================
// sslk_rsp_if
// Response channel: lookup flags and entry count with a valid/ready handshake.
// ============================================================================
`default_nettype none

interface sslk_rsp_if import sslk_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic               dropped;
  logic [COUNT_W-1:0] count;

  modport source (output valid, output found, output dropped, output count, input ready);
  modport sink   (input valid, input found, input dropped, input count, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sslk_cell.sv
// ============================================================================
// sslk_cell
// One slot of the sorted chain: holds an entry, shifts on insert, flags a match.
// ============================================================================
`default_nettype none

module sslk_cell import sslk_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cell_ctrl_t       ctrl,
  input  wire logic [VAL_W-1:0] key,
  input  wire logic [VAL_W-1:0] left_value,
  input  wire logic             left_ge,
  input  wire logic             left_valid,
  output logic      [VAL_W-1:0] value,
  output logic                  ge,
  output logic                  valid,
  output logic                  hit
);

  // An empty slot counts as holding a value above every key, so the
  // ge flags along the chain form a thermometer starting at the insert point.
  assign ge = !valid || (key <= value);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.insert && ge) begin
      valid <= left_valid;
    end
  end

  // The first slot at or above the insert point takes the key; the rest
  // take their left neighbor's entry.
  always_ff @(posedge clk) begin
    if (ctrl.insert && ge) begin
      value <= left_ge ? left_value : key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctrl.sample) begin
      hit <= valid && (value == key);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sorted_set_membership_lookup_core.sv
// ============================================================================
// sorted_set_membership_lookup_core
// Sorted table of up to DEPTH values kept in a chain of cells; clear, insert
// and membership query commands, one response beat per request beat.
// ============================================================================
// Requests are taken one at a time, in ST_IDLE; ST_GATHER and ST_REDUCE step
// through the two-level registered OR tree that gathers the per-cell match
// flags of a query, and ST_REDUCE waits until the output register is free.
// A request is taken while an earlier response still waits on the output.
// Reset: synchronous; empties the table and drops any beat in flight.
`default_nettype none

module sorted_set_membership_lookup_core import sslk_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  sslk_req_if.sink  req,
  sslk_rsp_if.source rsp
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_GATHER = 3'b010,
    ST_REDUCE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  logic             accept;
  logic             full;
  cmd_t             cmd;
  cell_ctrl_t       ctrl;

  logic [VAL_W-1:0] value_vec [DEPTH];
  logic [DEPTH-1:0] ge_vec;
  logic [DEPTH-1:0] valid_vec;
  logic [DEPTH-1:0] hit_vec;

  logic [NUM_GROUPS-1:0] grp;
  logic [NUM_GROUPS-1:0] grp_next;

  logic             s_query;
  logic             s_dropped;
  logic [CNT_W-1:0] s_count;
  logic             move_out;

  logic [CNT_W+COUNT_W-1:0] count_wide;

  assign cmd    = cmd_t'(req.command);
  assign accept = req.valid && req.ready;
  assign full   = valid_vec[DEPTH-1];

  assign ctrl.clear  = accept && (cmd == CMD_CLEAR);
  assign ctrl.insert = accept && (cmd == CMD_INSERT) && !full;
  assign ctrl.sample = accept;

  // Cell chain.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      sslk_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .key        (req.value),
        .left_value (req.value),
        .left_ge    (1'b0),
        .left_valid (1'b1),
        .value      (value_vec[i]),
        .ge         (ge_vec[i]),
        .valid      (valid_vec[i]),
        .hit        (hit_vec[i])
      );
    end else begin : g_body
      sslk_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .key        (req.value),
        .left_value (value_vec[i-1]),
        .left_ge    (ge_vec[i-1]),
        .left_valid (valid_vec[i-1]),
        .value      (value_vec[i]),
        .ge         (ge_vec[i]),
        .valid      (valid_vec[i]),
        .hit        (hit_vec[i])
      );
    end
  end

  // First level of the match reduction.
  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
    localparam int LO = g * GROUP;
    localparam int HI = ((LO + GROUP) < DEPTH) ? (LO + GROUP - 1) : (DEPTH - 1);
    assign grp_next[g] = |hit_vec[HI:LO];
  end

  always_comb begin
    cnt_next = cnt;
    if (ctrl.clear) begin
      cnt_next = '0;
    end else if (ctrl.insert) begin
      cnt_next = cnt + 1'b1;
    end
  end

  assign move_out = (state == ST_REDUCE) && (!rsp.valid || rsp.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_GATHER;
      ST_GATHER: state_next = ST_REDUCE;
      ST_REDUCE: if (move_out) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign req.ready = (state == ST_IDLE);

  // Per-beat side information taken at acceptance; group flags in ST_GATHER.
  always_ff @(posedge clk) begin
    if (accept) begin
      s_query   <= (cmd == CMD_QUERY);
      s_dropped <= (cmd == CMD_INSERT) && full;
      s_count   <= cnt_next;
    end
    if (state == ST_GATHER) begin
      grp <= grp_next;
    end
  end

  assign count_wide = {{COUNT_W{1'b0}}, s_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (move_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move_out) begin
      rsp.found   <= s_query && (|grp);
      rsp.dropped <= s_dropped;
      rsp.count   <= count_wide[COUNT_W-1:0];
    end
  end

  // The valid flags of the chain always match the entry count.
  a_count_matches_chain: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == cnt)
    else $error("entry count differs from occupied cells");

  // An insert never reaches the chain when the last cell is occupied.
  a_no_insert_when_full: assert property (@(posedge clk) disable iff (rst)
    ctrl.insert |-> !valid_vec[DEPTH-1])
    else $error("insert shifted an entry off the end of the chain");

  // A new response beat only comes out of the final reduction stage.
  a_rsp_from_reduce: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == ST_REDUCE))
    else $error("response raised without a finished request");

  // Request side stays closed while a beat is in flight.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("second request taken while one is in flight");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the sorted set lookup core. A directed table opens
// the run, then random clear/insert/query/reserved sequences fill, overflow
// and probe the table while both channels idle at random. Response beats are
// checked against typed table rows, else against a sorted-array predictor.
// ============================================================================
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sslk_pkg::*;

  // The command field has one code with no meaning; the core must ignore it.
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

  localparam int ITEMS_TARGET   = 1600;
  localparam int HOLD_AT        = 400;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic               found;
    logic               dropped;
    logic [COUNT_W-1:0] count;
  } lookup_result_t;

  typedef struct {
    logic [CMD_W-1:0] op;
    logic [VAL_W-1:0] v;
    bit               typed;
    lookup_result_t   res;
  } stim_row_t;

  localparam lookup_result_t UNTYPED = '0;

  logic clk = 1'b0;
  logic rst;

  sslk_req_if req_ch ();
  sslk_rsp_if rsp_ch ();

  sorted_set_membership_lookup_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // Shadow of the table, kept in ascending order.
  logic [VAL_W-1:0] sorted_vals [DEPTH];
  int unsigned      held_count = 0;

  lookup_result_t pending_results [$];
  int  mismatches = 0;
  int  items_sent = 0;
  int  burst_left = 0;
  int  quiet_cycles = 0;
  bit  stim_done = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;

  stim_row_t directed_rows [24] = '{
    '{CMD_QUERY,    16'h0000, 1'b1, '{1'b0, 1'b0, 9'd0}},
    '{CMD_QUERY,    16'hFFFF, 1'b1, '{1'b0, 1'b0, 9'd0}},
    '{CMD_INSERT,   16'hFFFF, 1'b1, '{1'b0, 1'b0, 9'd1}},
    '{CMD_INSERT,   16'h0000, 1'b1, '{1'b0, 1'b0, 9'd2}},
    '{CMD_QUERY,    16'h0000, 1'b1, '{1'b1, 1'b0, 9'd2}},
    '{CMD_QUERY,    16'hFFFF, 1'b1, '{1'b1, 1'b0, 9'd2}},
    '{CMD_QUERY,    16'h0001, 1'b0, UNTYPED},
    '{CMD_QUERY,    16'hFFFE, 1'b0, UNTYPED},
    '{CMD_INSERT,   16'h0000, 1'b1, '{1'b0, 1'b0, 9'd3}},
    '{CMD_INSERT,   16'h8000, 1'b0, UNTYPED},
    '{CMD_INSERT,   16'h7FFF, 1'b0, UNTYPED},
    '{CMD_QUERY,    16'h8000, 1'b0, UNTYPED},
    '{CMD_QUERY,    16'h7FFF, 1'b0, UNTYPED},
    '{CMD_INSERT,   16'h5555, 1'b0, UNTYPED},
    '{CMD_INSERT,   16'hAAAA, 1'b0, UNTYPED},
    '{CMD_QUERY,    16'hAAAA, 1'b0, UNTYPED},
    '{CMD_RESERVED, 16'hFFFF, 1'b1, '{1'b0, 1'b0, 9'd7}},
    '{CMD_RESERVED, 16'h0000, 1'b0, UNTYPED},
    '{CMD_CLEAR,    16'hFFFF, 1'b1, '{1'b0, 1'b0, 9'd0}},
    '{CMD_QUERY,    16'h0000, 1'b1, '{1'b0, 1'b0, 9'd0}},
    '{CMD_QUERY,    16'hFFFF, 1'b1, '{1'b0, 1'b0, 9'd0}},
    '{CMD_INSERT,   16'h1234, 1'b1, '{1'b0, 1'b0, 9'd1}},
    '{CMD_QUERY,    16'h1234, 1'b1, '{1'b1, 1'b0, 9'd1}},
    '{CMD_CLEAR,    16'h0000, 1'b1, '{1'b0, 1'b0, 9'd0}}
  };

  // First position whose entry is not below the key.
  function automatic int unsigned first_not_below(logic [VAL_W-1:0] key);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = held_count;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (key <= sorted_vals[mid]) hi = mid;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  function automatic lookup_result_t apply_table_op(logic [CMD_W-1:0] op,
                                                    logic [VAL_W-1:0] v);
    lookup_result_t r;
    int unsigned    pos;
    r = '0;
    case (op)
      CMD_CLEAR: held_count = 0;
      CMD_INSERT: begin
        if (held_count >= DEPTH) begin
          r.dropped = 1'b1;
        end else begin
          pos = first_not_below(v);
          for (int unsigned i = held_count; i > pos; i--) sorted_vals[i] = sorted_vals[i-1];
          sorted_vals[pos] = v;
          held_count++;
        end
      end
      CMD_QUERY: begin
        pos = first_not_below(v);
        r.found = (pos < held_count) && (sorted_vals[pos] == v);
      end
      default: ;
    endcase
    r.count = COUNT_W'(held_count);
    return r;
  endfunction

  // Value ranges: full width, a narrow band that forces duplicates, or edges.
  function automatic logic [VAL_W-1:0] pick_value(int vmode);
    case (vmode)
      1: return VAL_W'($urandom_range(0, 15));
      2: begin
        case ($urandom_range(0, 5))
          0: return 16'h0000;
          1: return 16'h0001;
          2: return 16'h7FFF;
          3: return 16'h8000;
          4: return 16'hFFFE;
          default: return 16'hFFFF;
        endcase
      end
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Mostly probe stored values and their neighbors so hits are common.
  function automatic logic [VAL_W-1:0] pick_probe(int vmode);
    logic [VAL_W-1:0] hit;
    if (held_count == 0 || $urandom_range(0, 3) == 0) return pick_value(vmode);
    hit = sorted_vals[$urandom_range(0, held_count - 1)];
    case ($urandom_range(0, 3))
      0: return hit + 1'b1;
      1: return hit - 1'b1;
      default: return hit;
    endcase
  endfunction

  task automatic send_op(input logic [CMD_W-1:0] op, input logic [VAL_W-1:0] v,
                         input bit typed, input lookup_result_t typed_res);
    int             gap;
    lookup_result_t predicted;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(1, 10);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
    req_ch.valid   <= 1'b1;
    req_ch.command <= op;
    req_ch.value   <= v;
    do @(posedge clk); while (!req_ch.ready);
    predicted = apply_table_op(op, v);
    pending_results.push_back(typed ? typed_res : predicted);
    if (op != CMD_RESERVED) items_sent++;
    if (items_sent >= HOLD_AT) hold_req = 1'b1;
  endtask

  // Fill the table to the top and push a few inserts past it.
  task automatic fill_to_overflow();
    int vmode;
    int extra;
    vmode = $urandom_range(0, 2);
    extra = $urandom_range(1, 4);
    if ($urandom_range(0, 1)) send_op(CMD_CLEAR, pick_value(0), 1'b0, UNTYPED);
    while (held_count < DEPTH || extra > 0) begin
      if ($urandom_range(0, 3) == 0) begin
        send_op(CMD_QUERY, pick_probe(vmode), 1'b0, UNTYPED);
      end else begin
        if (held_count == DEPTH) extra--;
        send_op(CMD_INSERT, pick_value(vmode), 1'b0, UNTYPED);
      end
    end
    repeat ($urandom_range(5, 20)) send_op(CMD_QUERY, pick_probe(vmode), 1'b0, UNTYPED);
  endtask

  task automatic short_run();
    int vmode;
    int pick;
    vmode = $urandom_range(0, 2);
    if ($urandom_range(0, 1)) send_op(CMD_CLEAR, pick_value(0), 1'b0, UNTYPED);
    repeat ($urandom_range(1, 30)) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) send_op(CMD_RESERVED, pick_value(0), 1'b0, UNTYPED);
      else if (pick < 13) send_op(CMD_INSERT, pick_value(vmode), 1'b0, UNTYPED);
      else send_op(CMD_QUERY, pick_probe(vmode), 1'b0, UNTYPED);
    end
  endtask

  task automatic noise_run();
    repeat ($urandom_range(5, 20))
      send_op(CMD_W'($urandom_range(0, 3)), pick_value(0), 1'b0, UNTYPED);
  endtask

  initial begin
    int pick;
    rst            <= 1'b1;
    req_ch.valid   <= 1'b0;
    req_ch.command <= CMD_CLEAR;
    req_ch.value   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i])
      send_op(directed_rows[i].op, directed_rows[i].v, directed_rows[i].typed,
              directed_rows[i].res);
    fill_to_overflow();
    while (items_sent < ITEMS_TARGET) begin
      pick = $urandom_range(0, 7);
      if (pick == 0) fill_to_overflow();
      else if (pick < 6) short_run();
      else noise_run();
    end
    req_ch.valid <= 1'b0;
    stim_done = 1'b1;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("sorted_set_membership_lookup_core: match");
    end else begin
      $display("sorted_set_membership_lookup_core: mismatch");
    end
    $finish;
  end

  // Response side: stretches of different stall patterns, plus one long
  // hold-off that lets the core back up into its request channel.
  initial begin
    int mode;
    int len;
    int period;
    rsp_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        mode   = $urandom_range(0, 3);
        len    = $urandom_range(20, 120);
        period = $urandom_range(2, 5);
        for (int c = 0; c < len; c++) begin
          case (mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= 1'($urandom_range(0, 1));
            2: rsp_ch.ready <= ((c % period) == 0);
            default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    lookup_result_t got;
    lookup_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = '{rsp_ch.found, rsp_ch.dropped, rsp_ch.count};
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: response beat with nothing expected: found=%0b dropped=%0b count=%0d",
                 $time, got.found, got.dropped, got.count);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: expected found=%0b dropped=%0b count=%0d, got found=%0b dropped=%0b count=%0d",
                   $time, want.found, want.dropped, want.count,
                   got.found, got.dropped, got.count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("sorted_set_membership_lookup_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
